// File: src/cnm_pkg.sv
// ----------------------------------------------------------------------------
// cnm_pkg
// Shared types and constants for the catalog nearest-match block.
// ----------------------------------------------------------------------------
package cnm_pkg;

  localparam int unsigned CATALOG_DEPTH_DEF = 16384;
  localparam int unsigned XREF_DEPTH_DEF    = 1024;
  localparam int unsigned IC_KEY_OFFSET_DEF = 10000;

  localparam logic [1:0] OP_LOAD_CAT  = 2'd0;
  localparam logic [1:0] OP_LOAD_XREF = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  localparam logic [1:0] TAG_STAR  = 2'd0;
  localparam logic [1:0] TAG_NGC   = 2'd1;
  localparam logic [1:0] TAG_IC    = 2'd2;
  localparam logic [1:0] TAG_OTHER = 2'd3;

  localparam logic [1:0] XKIND_MESSIER  = 2'd0;
  localparam logic [1:0] XKIND_CALDWELL = 2'd1;
  localparam logic [1:0] XKIND_HERSCHEL = 2'd2;
  localparam logic [1:0] XKIND_NONE     = 2'd3;

  localparam logic [1:0] ALT_NONE     = 2'd0;
  localparam logic [1:0] ALT_MESSIER  = 2'd1;
  localparam logic [1:0] ALT_CALDWELL = 2'd2;
  localparam logic [1:0] ALT_HERSCHEL = 2'd3;

  localparam logic REG_CATALOG_IN_USE = 1'b0;
  localparam logic REG_XREF_IN_USE    = 1'b1;

  localparam int unsigned CAT_W  = 50;
  localparam int unsigned XREF_W = 27;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_XREF,
    ST_DONE
  } cnm_state_t;

endpackage

// File: src/cnm_ram.sv
// ----------------------------------------------------------------------------
// cnm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/catalog_nearest_match_top.sv
// ----------------------------------------------------------------------------
// catalog_nearest_match_top
// Nearest catalog entry by squared RA/Dec distance, with cross-catalog lookup.
// ----------------------------------------------------------------------------
// Load operations write the catalog or cross-reference memory directly. A
// query reads the catalog memory one entry per cycle and then the
// cross-reference memory one entry per cycle, so it occupies the block until
// both passes are done (the cross-reference pass is skipped when there is no
// winner or the winner is a star); the single read port of each memory sets
// that pace. The finished result sits in an output register, and the block
// takes the next item while it waits there.
module catalog_nearest_match_top
  import cnm_pkg::*;
#(
  parameter int unsigned CATALOG_DEPTH = CATALOG_DEPTH_DEF,
  parameter int unsigned XREF_DEPTH    = XREF_DEPTH_DEF,
  parameter int unsigned IC_KEY_OFFSET = IC_KEY_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_slot,
  input  logic [15:0] in_ra_raw,
  input  logic signed [15:0] in_dec_raw,
  input  logic [1:0]  in_source_tag,
  input  logic [15:0] in_object_id,
  input  logic [1:0]  in_xref_kind,
  input  logic [8:0]  in_xref_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_found_source,
  output logic [15:0] out_found_object,
  output logic [32:0] out_distance_sq,
  output logic        out_found_any,
  output logic [1:0]  out_alt_kind,
  output logic [8:0]  out_alt_number
);

  localparam int unsigned CAW = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
  localparam int unsigned CCW = $clog2(CATALOG_DEPTH + 1);
  localparam int unsigned XAW = (XREF_DEPTH > 1) ? $clog2(XREF_DEPTH) : 1;
  localparam int unsigned XCW = $clog2(XREF_DEPTH + 1);

  logic [14:0] cat_in_use_r;
  logic [10:0] xref_in_use_r;

  cnm_state_t state_r, state_nxt;
  logic in_acc;

  logic [CCW-1:0] idx_r, idx_nxt, n_r;
  logic [XCW-1:0] xidx_r, xidx_nxt, xn_r;
  logic cat_issue, xref_issue;
  logic v1_r, v2_r, xv1_r;

  logic [15:0] t_ra_r;
  logic signed [15:0] t_dec_r;

  logic [CAT_W-1:0]  cat_rdata;
  logic [XREF_W-1:0] xref_rdata;
  logic cat_we, xref_we;

  // Squares stage.
  logic signed [16:0] dr, dd;
  logic signed [33:0] dr_sq, dd_sq;
  logic [31:0] ra_sq_r, dec_sq_r;
  logic [1:0]  s2_tag_r;
  logic [15:0] s2_obj_r;
  logic [32:0] dist_sum;

  logic        best_valid_r;
  logic [32:0] best_d_r;
  logic [1:0]  best_tag_r;
  logic [15:0] best_obj_r;

  logic [15:0] key;
  logic [2:0]  xfound_r;
  logic [8:0]  xnum_r [3];
  logic        xhit;

  logic [1:0] alt_kind;
  logic [8:0] alt_num;
  logic       out_free;
  logic       out_valid_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cat_we  = in_acc && (in_opcode == OP_LOAD_CAT) &&
                   ({18'd0, in_slot} < 32'(CATALOG_DEPTH));
  assign xref_we = in_acc && (in_opcode == OP_LOAD_XREF) &&
                   ({18'd0, in_slot} < 32'(XREF_DEPTH));

  cnm_ram #(.WIDTH(CAT_W), .DEPTH(CATALOG_DEPTH)) u_cat_ram (
    .clk   (clk),
    .we    (cat_we),
    .waddr (CAW'(in_slot)),
    .wdata ({in_ra_raw, in_dec_raw, in_source_tag, in_object_id}),
    .raddr (idx_r[CAW-1:0]),
    .rdata (cat_rdata)
  );

  cnm_ram #(.WIDTH(XREF_W), .DEPTH(XREF_DEPTH)) u_xref_ram (
    .clk   (clk),
    .we    (xref_we),
    .waddr (XAW'(in_slot)),
    .wdata ({in_object_id, in_xref_kind, in_xref_number}),
    .raddr (xidx_r[XAW-1:0]),
    .rdata (xref_rdata)
  );

  assign cat_issue  = (state_r == ST_SCAN) && (idx_r < n_r);
  assign xref_issue = (state_r == ST_XREF) && (xidx_r < xn_r);

  // Catalog word layout: ra, dec, tag, object.
  assign dr       = $signed({1'b0, cat_rdata[49:34]}) - $signed({1'b0, t_ra_r});
  assign dd       = $signed({cat_rdata[33], cat_rdata[33:18]}) - $signed({t_dec_r[15], t_dec_r});
  assign dr_sq    = dr * dr;
  assign dd_sq    = dd * dd;
  assign dist_sum = {1'b0, ra_sq_r} + {1'b0, dec_sq_r};

  assign key = (best_tag_r == TAG_IC) ? best_obj_r + IC_KEY_OFFSET[15:0] : best_obj_r;

  // Cross-reference word layout: key, kind, number. Kind three never matches.
  assign xhit = xv1_r && (xref_rdata[26:11] == key) && (xref_rdata[10:9] != XKIND_NONE) &&
                !xfound_r[xref_rdata[10:9]];

  always_comb begin
    alt_kind = ALT_NONE;
    alt_num  = '0;
    if (xfound_r[XKIND_MESSIER]) begin
      alt_kind = ALT_MESSIER;
      alt_num  = xnum_r[XKIND_MESSIER];
    end else if (xfound_r[XKIND_CALDWELL]) begin
      alt_kind = ALT_CALDWELL;
      alt_num  = xnum_r[XKIND_CALDWELL];
    end else if (xfound_r[XKIND_HERSCHEL] && best_tag_r == TAG_NGC) begin
      alt_kind = ALT_HERSCHEL;
      alt_num  = xnum_r[XKIND_HERSCHEL];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    xidx_nxt  = xidx_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt  = '0;
        xidx_nxt = '0;
        if (in_acc && in_opcode == OP_QUERY) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cat_issue) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!v1_r && !v2_r) begin
          if (!best_valid_r || best_tag_r == TAG_STAR) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_XREF;
          end
        end
      end
      ST_XREF: begin
        if (xref_issue) begin
          xidx_nxt = xidx_r + 1'b1;
        end else if (!xv1_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cat_in_use_r  <= '0;
      xref_in_use_r <= '0;
      idx_r         <= '0;
      xidx_r        <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      xv1_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      best_valid_r  <= 1'b0;
      xfound_r      <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      xidx_r  <= xidx_nxt;
      v1_r    <= cat_issue;
      v2_r    <= v1_r;
      xv1_r   <= xref_issue;
      if (cfg_we && cfg_index == REG_CATALOG_IN_USE) begin
        cat_in_use_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_XREF_IN_USE) begin
        xref_in_use_r <= cfg_wdata[10:0];
      end
      if (in_acc && in_opcode == OP_QUERY) begin
        best_valid_r <= 1'b0;
        xfound_r     <= '0;
      end
      if (v2_r && (!best_valid_r || dist_sum < best_d_r)) begin
        best_valid_r <= 1'b1;
      end
      if (xhit) begin
        xfound_r[xref_rdata[10:9]] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OP_QUERY) begin
      t_ra_r     <= in_ra_raw;
      t_dec_r    <= in_dec_raw;
      n_r        <= ({17'd0, cat_in_use_r} >= 32'(CATALOG_DEPTH)) ?
                    CCW'(CATALOG_DEPTH) : CCW'(cat_in_use_r);
      xn_r       <= ({21'd0, xref_in_use_r} >= 32'(XREF_DEPTH)) ?
                    XCW'(XREF_DEPTH) : XCW'(xref_in_use_r);
      best_d_r   <= '0;
      best_tag_r <= '0;
      best_obj_r <= '0;
    end
    if (v1_r) begin
      ra_sq_r  <= dr_sq[31:0];
      dec_sq_r <= dd_sq[31:0];
      s2_tag_r <= cat_rdata[17:16];
      s2_obj_r <= cat_rdata[15:0];
    end
    // Strict less-than keeps the lowest index on ties.
    if (v2_r && (!best_valid_r || dist_sum < best_d_r)) begin
      best_d_r   <= dist_sum;
      best_tag_r <= s2_tag_r;
      best_obj_r <= s2_obj_r;
    end
    if (xhit) begin
      xnum_r[xref_rdata[10:9]] <= xref_rdata[8:0];
    end
    if (state_r == ST_DONE && out_free) begin
      out_found_source <= best_tag_r;
      out_found_object <= best_obj_r;
      out_distance_sq  <= best_d_r;
      out_found_any    <= best_valid_r;
      out_alt_kind     <= alt_kind;
      out_alt_number   <= alt_num;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: verif/cnm_checker.sv
// ----------------------------------------------------------------------------
// cnm_checker
// Watches the configuration port and both channels of the catalog nearest-match
// block, keeps its own copy of both memories and the count registers, predicts
// the result of every accepted query and compares each result transfer with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cnm_checker
  import cnm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [13:0]        in_slot,
  input  logic [15:0]        in_ra_raw,
  input  logic signed [15:0] in_dec_raw,
  input  logic [1:0]         in_source_tag,
  input  logic [15:0]        in_object_id,
  input  logic [1:0]         in_xref_kind,
  input  logic [8:0]         in_xref_number,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_found_source,
  input  logic [15:0]        out_found_object,
  input  logic [32:0]        out_distance_sq,
  input  logic               out_found_any,
  input  logic [1:0]         out_alt_kind,
  input  logic [8:0]         out_alt_number,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]  source;
    logic [15:0] object;
    logic [32:0] distance;
    logic        any;
    logic [1:0]  alt_kind;
    logic [8:0]  alt_num;
  } match_t;

  logic [15:0]        cat_ra  [CATALOG_DEPTH_DEF];
  logic signed [15:0] cat_dec [CATALOG_DEPTH_DEF];
  logic [1:0]         cat_tag [CATALOG_DEPTH_DEF];
  logic [15:0]        cat_obj [CATALOG_DEPTH_DEF];
  logic [15:0]        xr_key  [XREF_DEPTH_DEF];
  logic [1:0]         xr_kind [XREF_DEPTH_DEF];
  logic [8:0]         xr_num  [XREF_DEPTH_DEF];
  logic [14:0]        cat_count;
  logic [10:0]        xref_count;
  match_t             match_queue [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    cat_count  = '0;
    xref_count = '0;
  end

  // Returns the list number of the first entry of that kind holding the key,
  // or -1 when none does.
  function automatic int xref_lookup(logic [1:0] kind, logic [15:0] key);
    int n;
    n = (xref_count > XREF_DEPTH_DEF) ? XREF_DEPTH_DEF : int'(xref_count);
    for (int i = 0; i < n; i++) begin
      if (xr_kind[i] == kind && xr_key[i] == key) return int'(xr_num[i]);
    end
    return -1;
  endfunction

  function automatic match_t nearest_match(logic [15:0] ra, logic signed [15:0] dec);
    int      n;
    int      bi;
    int      hit;
    longint  dr;
    longint  dd;
    longint  d;
    longint  best;
    logic [15:0] key;
    match_t  m;
    m    = '0;
    bi   = 0;
    best = 0;
    n = (cat_count > CATALOG_DEPTH_DEF) ? CATALOG_DEPTH_DEF : int'(cat_count);
    if (n == 0) return m;
    for (int i = 0; i < n; i++) begin
      dr = longint'(cat_ra[i]) - longint'(ra);
      dd = longint'(cat_dec[i]) - longint'(dec);
      d  = dr * dr + dd * dd;
      if (i == 0 || d < best) begin
        best = d;
        bi   = i;
      end
    end
    m.source   = cat_tag[bi];
    m.object   = cat_obj[bi];
    m.distance = best[32:0];
    m.any      = 1'b1;
    if (cat_tag[bi] != TAG_STAR) begin
      key = cat_obj[bi];
      if (cat_tag[bi] == TAG_IC) key = key + 16'(IC_KEY_OFFSET_DEF);
      hit = xref_lookup(XKIND_MESSIER, key);
      if (hit >= 0) begin
        m.alt_kind = ALT_MESSIER;
        m.alt_num  = hit[8:0];
      end else begin
        hit = xref_lookup(XKIND_CALDWELL, key);
        if (hit >= 0) begin
          m.alt_kind = ALT_CALDWELL;
          m.alt_num  = hit[8:0];
        end else if (cat_tag[bi] == TAG_NGC) begin
          // Herschel entries only count for NGC winners.
          hit = xref_lookup(XKIND_HERSCHEL, key);
          if (hit >= 0) begin
            m.alt_kind = ALT_HERSCHEL;
            m.alt_num  = hit[8:0];
          end
        end
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin
    match_t want;
    if (rst_n) begin
      // Results are compared before new queries are queued, so a result can
      // never be matched against a query accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (match_queue.size() == 0) begin
          $display("%0t: result transfer with no query outstanding", $realtime);
          fail_count++;
        end else begin
          want = match_queue.pop_front();
          if (out_found_source !== want.source) begin
            $display("%0t: found_source expected %0d actual %0d",
                     $realtime, want.source, out_found_source);
            fail_count++;
          end
          if (out_found_object !== want.object) begin
            $display("%0t: found_object expected %0d actual %0d",
                     $realtime, want.object, out_found_object);
            fail_count++;
          end
          if (out_distance_sq !== want.distance) begin
            $display("%0t: distance_sq expected %0d actual %0d",
                     $realtime, want.distance, out_distance_sq);
            fail_count++;
          end
          if (out_found_any !== want.any) begin
            $display("%0t: found_any expected %0d actual %0d",
                     $realtime, want.any, out_found_any);
            fail_count++;
          end
          if (out_alt_kind !== want.alt_kind) begin
            $display("%0t: alt_kind expected %0d actual %0d",
                     $realtime, want.alt_kind, out_alt_kind);
            fail_count++;
          end
          if (out_alt_number !== want.alt_num) begin
            $display("%0t: alt_number expected %0d actual %0d",
                     $realtime, want.alt_num, out_alt_number);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CATALOG_IN_USE) cat_count = cfg_wdata;
        else xref_count = cfg_wdata[10:0];
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LOAD_CAT: begin
            cat_ra[in_slot]  = in_ra_raw;
            cat_dec[in_slot] = in_dec_raw;
            cat_tag[in_slot] = in_source_tag;
            cat_obj[in_slot] = in_object_id;
          end
          OP_LOAD_XREF: begin
            if (in_slot < XREF_DEPTH_DEF) begin
              xr_key[in_slot]  = in_object_id;
              xr_kind[in_slot] = in_xref_kind;
              xr_num[in_slot]  = in_xref_number;
            end
          end
          OP_QUERY: match_queue.push_back(nearest_match(in_ra_raw, in_dec_raw));
          default: ;
        endcase
      end
      pending = match_queue.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the catalog nearest-match block: directed loads and queries for
// ties, priorities, key offset and the extremes, then rounds of random loads
// and queries under several count settings.
// ----------------------------------------------------------------------------
module tb_top;
  import cnm_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [14:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_opcode;
  logic [13:0]        in_slot;
  logic [15:0]        in_ra_raw;
  logic signed [15:0] in_dec_raw;
  logic [1:0]         in_source_tag;
  logic [15:0]        in_object_id;
  logic [1:0]         in_xref_kind;
  logic [8:0]         in_xref_number;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_found_source;
  logic [15:0]        out_found_object;
  logic [32:0]        out_distance_sq;
  logic               out_found_any;
  logic [1:0]         out_alt_kind;
  logic [8:0]         out_alt_number;
  int                 fail_count;
  int                 pending;

  logic               no_idle = 1'b0;
  int                 cur_cat = 0;
  int                 cur_xref = 0;
  int                 cat_prefix = 0;
  int                 xr_prefix = 0;
  int                 n_query = 0;
  int                 n_load = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  catalog_nearest_match_top DUT (.*);

  cnm_checker u_checker (.*);

  always @(posedge clk) out_stall <= !no_idle && ($urandom_range(0, 99) < 29);

  task automatic send_item(input logic [1:0] op, input logic [13:0] slot,
                           input logic [15:0] ra, input logic [15:0] dec,
                           input logic [1:0] tag, input logic [15:0] obj,
                           input logic [1:0] kind, input logic [8:0] num);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_slot        <= slot;
    in_ra_raw      <= ra;
    in_dec_raw     <= dec;
    in_source_tag  <= tag;
    in_object_id   <= obj;
    in_xref_kind   <= kind;
    in_xref_number <= num;
    do @(posedge clk); while (in_stall);
    if (op == OP_QUERY) n_query++;
    else if (op != OP_NONE) n_load++;
    if (op == OP_LOAD_CAT && int'(slot) == cat_prefix) cat_prefix++;
    if (op == OP_LOAD_XREF && int'(slot) == xr_prefix && xr_prefix < XREF_DEPTH_DEF)
      xr_prefix++;
  endtask

  // Waits for every outstanding result, then for a full query's worth of
  // cycles so that a scan with no result still pending has ended too.
  // The first edge lets the checker count a query accepted at the last edge.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (cur_cat + cur_xref + 20) @(posedge clk);
  endtask

  task automatic set_counts(input int cat, input int xref);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CATALOG_IN_USE;
    cfg_wdata <= 15'(cat);
    @(posedge clk);
    cfg_index <= REG_XREF_IN_USE;
    cfg_wdata <= 15'(xref);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cat  = (cat > CATALOG_DEPTH_DEF) ? CATALOG_DEPTH_DEF : cat;
    cur_xref = (xref > XREF_DEPTH_DEF) ? XREF_DEPTH_DEF : xref;
  endtask

  task automatic query(input logic [15:0] ra, input logic [15:0] dec);
    send_item(OP_QUERY, 14'($urandom), ra, dec, 2'($urandom), 16'($urandom),
              2'($urandom), 9'($urandom));
  endtask

  task automatic random_item;
    int          pick;
    logic [13:0] slot;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if (cat_prefix < 64 && $urandom_range(0, 1)) slot = 14'(cat_prefix);
      else if ($urandom_range(0, 9) == 0) slot = 14'($urandom);
      else slot = 14'($urandom_range(0, cat_prefix));
      key = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      send_item(OP_LOAD_CAT, slot, 16'($urandom), 16'($urandom), 2'($urandom),
                key, 2'($urandom), 9'($urandom));
    end else if (pick < 50) begin
      // Some slots lie beyond the memory and the load is dropped.
      if ($urandom_range(0, 7) == 0) slot = 14'($urandom_range(XREF_DEPTH_DEF, 16383));
      else if (xr_prefix < 64 && $urandom_range(0, 1)) slot = 14'(xr_prefix);
      else slot = 14'($urandom_range(0, xr_prefix));
      key = 16'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) key = key + 16'(IC_KEY_OFFSET_DEF);
      send_item(OP_LOAD_XREF, slot, 16'($urandom), 16'($urandom), 2'($urandom),
                key, 2'($urandom), 9'($urandom));
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0: query(($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                 ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000));
        default: query(16'($urandom), 16'($urandom));
      endcase
    end else begin
      send_item(OP_NONE, 14'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                16'($urandom), 2'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CATALOG_IN_USE;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_LOAD_CAT;
    in_slot        <= '0;
    in_ra_raw      <= '0;
    in_dec_raw     <= '0;
    in_source_tag  <= TAG_STAR;
    in_object_id   <= '0;
    in_xref_kind   <= XKIND_MESSIER;
    in_xref_number <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty catalog after reset.
    query(16'd1234, 16'd55);
    // An NGC entry at one corner, an IC entry at the opposite corner whose key
    // wraps past 16 bits, a star tied with an NGC entry, and a lone NGC entry.
    send_item(OP_LOAD_CAT, 14'd0, 16'h0000, 16'h8000, TAG_NGC, 16'd100, 2'd0, 9'd0);
    send_item(OP_LOAD_CAT, 14'd1, 16'hFFFF, 16'h7FFF, TAG_IC, 16'd60000, 2'd0, 9'd0);
    send_item(OP_LOAD_CAT, 14'd2, 16'd1000, 16'd1000, TAG_STAR, 16'd7, 2'd0, 9'd0);
    send_item(OP_LOAD_CAT, 14'd3, 16'd1000, 16'd1000, TAG_NGC, 16'd200, 2'd0, 9'd0);
    send_item(OP_LOAD_CAT, 14'd4, 16'd5000, 16'd5000, TAG_NGC, 16'd200, 2'd0, 9'd0);
    send_item(OP_LOAD_XREF, 14'd0, 16'd0, 16'd0, TAG_STAR, 16'd100, XKIND_CALDWELL, 9'd5);
    send_item(OP_LOAD_XREF, 14'd1, 16'd0, 16'd0, TAG_STAR, 16'd100, XKIND_MESSIER, 9'd31);
    send_item(OP_LOAD_XREF, 14'd2, 16'd0, 16'd0, TAG_STAR, 16'd4464, XKIND_HERSCHEL, 9'd9);
    send_item(OP_LOAD_XREF, 14'd3, 16'd0, 16'd0, TAG_STAR, 16'd4464, XKIND_CALDWELL, 9'd65);
    send_item(OP_LOAD_XREF, 14'd4, 16'd0, 16'd0, TAG_STAR, 16'd200, XKIND_NONE, 9'd1);
    send_item(OP_LOAD_XREF, 14'd5, 16'd0, 16'd0, TAG_STAR, 16'd200, XKIND_HERSCHEL, 9'd400);
    send_item(OP_LOAD_XREF, 14'd6, 16'd0, 16'd0, TAG_STAR, 16'd200, XKIND_HERSCHEL, 9'd511);
    send_item(OP_LOAD_XREF, 14'd2000, 16'd0, 16'd0, TAG_STAR, 16'd100, XKIND_MESSIER, 9'd1);
    send_item(OP_NONE, 14'h3FFF, 16'hFFFF, 16'hFFFF, TAG_OTHER, 16'hFFFF, XKIND_NONE, 9'h1FF);
    drain();
    set_counts(5, 7);
    query(16'h0000, 16'h8000);
    query(16'hFFFF, 16'h7FFF);
    query(16'd1000, 16'd1000);
    query(16'd5000, 16'd5001);
    query(16'hFFFF, 16'h8000);
    drain();
    // Only the bottom corner entry against the top corner target.
    set_counts(1, 0);
    query(16'hFFFF, 16'h7FFF);

    for (int r = 0; r < 6; r++) begin
      drain();
      if (r == 1) set_counts(0, xr_prefix);
      else set_counts($urandom_range(1, cat_prefix), $urandom_range(0, xr_prefix));
      no_idle = (r == 2);
      for (int k = 0; k < 13; k++) begin
        random_item();
        if (r == 3 && k == 6) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    no_idle = 1'b0;
    drain();

    $display("Covered %0d queries and %0d loads, counts from empty up to the loaded entries,",
             n_query, n_load);
    $display("with ties, list priority, IC key offset and dropped opcodes and slots.");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
